>>> rtl/postfix_expression_evaluator_assert.svh
// assertion macros for the port level checker of the postfix evaluator
`ifndef POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH

// checked only while out of reset
`define PFE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define PFE_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/pfe_pkg.sv
// types, constants and helpers of the postfix expression evaluator
`default_nettype none

package pfe_pkg;

	localparam int DATA_W      = 32;
	localparam int DIGIT_W     = 4;
	localparam int SYMBOL_W    = 8;
	localparam int STACK_DEPTH = 16;
	localparam int STACK_AW    = $clog2(STACK_DEPTH);
	localparam int STACK_CW    = $clog2(STACK_DEPTH + 1);
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [SYMBOL_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [SYMBOL_W-1:0] CH_NINE  = 8'h39;
	localparam logic [SYMBOL_W-1:0] CH_PLUS  = 8'h2b;
	localparam logic [SYMBOL_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [SYMBOL_W-1:0] CH_STAR  = 8'h2a;
	localparam logic [SYMBOL_W-1:0] CH_SLASH = 8'h2f;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_OVERFLOW  = 2'd2,
		ST_DIVZERO   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		OP_NOP   = 3'd0,
		OP_DIGIT = 3'd1,
		OP_ADD   = 3'd2,
		OP_SUB   = 3'd3,
		OP_MUL   = 3'd4,
		OP_DIV   = 3'd5
	} op_t;

	typedef struct packed {
		logic [SYMBOL_W-1:0] symbol;
		logic                end_of_expression;
	} in_word_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result_value;
		status_t                  status;
	} out_word_t;

	typedef struct packed {
		op_t                op;
		logic [DIGIT_W-1:0] digit;
		logic               last;
	} cmd_t;

	function automatic status_t note_error(input status_t cur, input status_t code);
		return (cur == ST_OK) ? code : cur;
	endfunction

endpackage

`default_nettype wire

>>> rtl/pfe_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module pfe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/pfe_front.sv
// front end: symbol classification and the command queue
`default_nettype none

module pfe_front import pfe_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	output logic          full,
	input  wire in_word_t item,
	output logic          cmd_valid,
	output cmd_t          cmd,
	input  wire logic     cmd_pop
);

	cmd_t                entries_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;
	cmd_t                cls;
	logic                push_ok;
	logic                pop_ok;
	logic [SYMBOL_W-1:0] offset;

	assign full      = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign cmd_valid = (count_q != '0);
	assign cmd       = entries_q[rd_ptr_q];
	assign push_ok   = push && !full;
	assign pop_ok    = cmd_pop && cmd_valid;
	assign offset    = item.symbol - CH_ZERO;

	always_comb begin
		cls.digit = offset[DIGIT_W-1:0];
		cls.last  = item.end_of_expression;
		unique if (item.symbol >= CH_ZERO && item.symbol <= CH_NINE) begin
			cls.op = OP_DIGIT;
		end else if (item.symbol == CH_PLUS) begin
			cls.op = OP_ADD;
		end else if (item.symbol == CH_MINUS) begin
			cls.op = OP_SUB;
		end else if (item.symbol == CH_STAR) begin
			cls.op = OP_MUL;
		end else if (item.symbol == CH_SLASH) begin
			cls.op = OP_DIV;
		end else begin
			cls.op = OP_NOP;
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			entries_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + QUEUE_CW'(1);
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - QUEUE_CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/pfe_div.sv
// iterative signed divider, one quotient bit per cycle, truncating toward zero
`default_nettype none

module pfe_div import pfe_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DATA_W-1:0] dividend,
	input  wire logic [DATA_W-1:0] divisor,
	output logic                   done,
	output logic      [DATA_W-1:0] quotient
);

	localparam int STEP_W = $clog2(DATA_W);

	typedef enum logic [2:0] {
		DV_IDLE = 3'b001,
		DV_RUN  = 3'b010,
		DV_FIX  = 3'b100
	} div_state_t;

	div_state_t        state_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DATA_W-1:0] num_q;
	logic [DATA_W-1:0] den_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic              neg_q;
	logic [DATA_W:0]   rem_sh;
	logic [DATA_W:0]   diff;
	logic              ge;
	logic [DATA_W-1:0] mag_a;
	logic [DATA_W-1:0] mag_b;

	assign rem_sh   = {rem_q, num_q[DATA_W-1]};
	assign ge       = (rem_sh >= {1'b0, den_q});
	assign diff     = rem_sh - {1'b0, den_q};
	assign mag_a    = dividend[DATA_W-1] ? (~dividend + DATA_W'(1)) : dividend;
	assign mag_b    = divisor[DATA_W-1] ? (~divisor + DATA_W'(1)) : divisor;
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			done_q  <= 1'b0;
			step_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				DV_IDLE: begin
					if (start) begin
						step_q  <= '0;
						state_q <= DV_RUN;
					end
				end
				DV_RUN: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(DATA_W - 1)) begin
						state_q <= DV_FIX;
					end
				end
				DV_FIX: begin
					done_q  <= 1'b1;
					state_q <= DV_IDLE;
				end
				default: state_q <= DV_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == DV_IDLE && start) begin
			num_q <= mag_a;
			den_q <= mag_b;
			rem_q <= '0;
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
		end else if (state_q == DV_RUN) begin
			rem_q <= ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
			num_q <= {num_q[DATA_W-2:0], ge};
		end
		if (state_q == DV_FIX) begin
			quo_q <= neg_q ? (~num_q + DATA_W'(1)) : num_q;
		end
	end

endmodule

`default_nettype wire

>>> rtl/pfe_back.sv
// back end: operand stack, arithmetic sequencer and result register
`default_nettype none

module pfe_back import pfe_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cmd_valid,
	input  wire cmd_t  cmd,
	output logic       cmd_pop,
	input  wire logic  pop,
	output logic       empty,
	output out_word_t  result
);

	typedef enum logic [6:0] {
		BK_IDLE = 7'b0000001,
		BK_RHS  = 7'b0000010,
		BK_LHS  = 7'b0000100,
		BK_DIV  = 7'b0001000,
		BK_WB   = 7'b0010000,
		BK_FIN  = 7'b0100000,
		BK_EMIT = 7'b1000000
	} back_state_t;

	back_state_t         state_q;
	back_state_t         state_d;
	back_state_t         after;
	cmd_t                cmd_q;
	logic [STACK_CW-1:0] cnt_q;
	logic [STACK_CW-1:0] cnt_d;
	logic [STACK_CW-1:0] cnt_m1;
	logic [STACK_CW-1:0] cnt_m2;
	status_t             err_q;
	status_t             err_d;
	logic [DATA_W-1:0]   rhs_q;
	logic [DATA_W-1:0]   res_q;
	logic                wr_en;
	logic [STACK_AW-1:0] wr_addr;
	logic [DATA_W-1:0]   wr_data;
	logic                rd_en;
	logic [STACK_AW-1:0] rd_addr;
	logic [DATA_W-1:0]   rd_data;
	logic                div_start;
	logic                div_done;
	logic [DATA_W-1:0]   div_quo;
	logic                out_valid_q;
	out_word_t           out_q;
	logic                out_load;
	logic                out_free;

	assign cnt_m1   = cnt_q - STACK_CW'(1);
	assign cnt_m2   = cnt_q - STACK_CW'(2);
	assign after    = cmd_q.last ? BK_FIN : BK_IDLE;
	assign out_free = !out_valid_q || pop;
	assign empty    = !out_valid_q;
	assign result   = out_q;

	pfe_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	pfe_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(rd_data),
		.divisor (rhs_q),
		.done    (div_done),
		.quotient(div_quo)
	);

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		err_d     = err_q;
		cmd_pop   = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = cnt_m2[STACK_AW-1:0];
		wr_data   = res_q;
		rd_en     = 1'b0;
		rd_addr   = cnt_m1[STACK_AW-1:0];
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					state_d = cmd.last ? BK_FIN : BK_IDLE;
					unique case (cmd.op)
						OP_DIGIT: begin
							if (cnt_q == STACK_CW'(STACK_DEPTH)) begin
								err_d = note_error(err_q, ST_OVERFLOW);
							end else begin
								wr_en   = 1'b1;
								wr_addr = cnt_q[STACK_AW-1:0];
								wr_data = {{(DATA_W - DIGIT_W){1'b0}}, cmd.digit};
								cnt_d   = cnt_q + STACK_CW'(1);
							end
						end
						OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
							if (cnt_q < STACK_CW'(2)) begin
								err_d = note_error(err_q, ST_UNDERFLOW);
							end else begin
								rd_en   = 1'b1;
								state_d = BK_RHS;
							end
						end
						default: ;
					endcase
				end
			end
			BK_RHS: begin
				rd_en   = 1'b1;
				rd_addr = cnt_m2[STACK_AW-1:0];
				state_d = BK_LHS;
			end
			BK_LHS: begin
				if (cmd_q.op == OP_DIV) begin
					if (rhs_q == '0) begin
						err_d   = note_error(err_q, ST_DIVZERO);
						cnt_d   = cnt_m2;
						state_d = after;
					end else begin
						div_start = 1'b1;
						state_d   = BK_DIV;
					end
				end else begin
					state_d = BK_WB;
				end
			end
			BK_DIV: begin
				if (div_done) begin
					state_d = BK_WB;
				end
			end
			BK_WB: begin
				wr_en   = 1'b1;
				cnt_d   = cnt_m1;
				state_d = after;
			end
			BK_FIN: begin
				rd_en   = 1'b1;
				state_d = BK_EMIT;
			end
			BK_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					cnt_d    = '0;
					err_d    = ST_OK;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			cnt_q       <= '0;
			err_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			err_q   <= err_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (state_q == BK_RHS) begin
			rhs_q <= rd_data;
		end
		if (state_q == BK_LHS) begin
			unique case (cmd_q.op)
				OP_ADD:  res_q <= rd_data + rhs_q;
				OP_SUB:  res_q <= rd_data - rhs_q;
				OP_MUL:  res_q <= rd_data * rhs_q;
				default: res_q <= res_q;
			endcase
		end else if (state_q == BK_DIV && div_done) begin
			res_q <= div_quo;
		end
		if (out_load) begin
			out_q.result_value <= (cnt_q == '0) ? '0 : $signed(rd_data);
			out_q.status       <= err_q;
		end
	end

endmodule

`default_nettype wire

>>> rtl/postfix_expression_evaluator.sv
// top level of the postfix expression evaluator
//
// Evaluates postfix expressions one ASCII character per word: a digit pushes its value on a
// 16-entry stack, + - * / pop two operands and push the 32-bit signed result (wrapping,
// division truncating toward zero), other characters are ignored. A word marked
// end_of_expression yields one result word with the top of stack (0 if empty) and the first
// error of the expression, then clears the stack. Input words go through a two-word queue,
// so a few may be taken while the back end works. The back end takes a digit or ignored
// character directly; + - and * read the right then the left operand from the single-read-port
// stack memory, one after the other, then compute and write back, and / instead starts the
// bit-serial divider, which makes one quotient bit per cycle, and waits for it; an end-marked
// word then reads the top of stack and waits for the result register to be free.
`default_nettype none

module postfix_expression_evaluator import pfe_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	output logic          full,
	input  wire in_word_t item,
	output logic          empty,
	input  wire logic     pop,
	output out_word_t     result
);

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;

	pfe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop)
	);

	pfe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

endmodule

`default_nettype wire

>>> rtl/pfe_checker.sv
// port level checker for the postfix expression evaluator, bound to the top level
`default_nettype none

`include "postfix_expression_evaluator_assert.svh"

module pfe_checker import pfe_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      push,
	input wire logic      full,
	input wire in_word_t  item,
	input wire logic      empty,
	input wire logic      pop,
	input wire out_word_t result
);

	`PFE_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> (empty && !full), "not idle in reset")
	`PFE_ASSERT(a_result_held, !empty && !pop |=> !empty && $stable(result), "result word not held")
	`PFE_ASSERT(a_full_needs_push, $rose(full) |-> $past(push), "queue filled without a push")
	`PFE_ASSERT(a_empty_needs_pop, $rose(empty) |-> $past(pop), "result word dropped without a pop")

endmodule

bind postfix_expression_evaluator pfe_checker u_pfe_checker (.*);

`default_nettype wire

>>> bench/postfix_expression_evaluator_checker.sv
// checker for the postfix expression evaluator: predicts results from the accepted words
module postfix_expression_evaluator_checker import pfe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  logic      full,
	input  in_word_t  item,
	input  logic      empty,
	input  logic      pop,
	input  out_word_t result,
	output int        fail_count,
	output int        results_due,
	output int        results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [DATA_W-1:0] operand_mem [STACK_DEPTH];
	int                operand_count;
	status_t           first_error;
	out_word_t         pending_results [$];

	function automatic void keep_first_error(input status_t code);
		if (first_error == ST_OK)
			first_error = code;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		op_t               op;
		logic [DATA_W-1:0] lhs;
		logic [DATA_W-1:0] rhs;
		logic [DATA_W-1:0] res;
		longint            quotient;
		bit                pushes;
		out_word_t         want;
		if (!arst_n) begin
			operand_count = 0;
			first_error = ST_OK;
			pending_results.delete();
			fail_count = 0;
			results_due = 0;
			results_seen = 0;
		end else begin
			if (pop && !empty) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result word value %0d status %0d",
						$time, result.result_value, result.status);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (result.result_value !== want.result_value) begin
						$display("%0t: result_value mismatch, expected %0d actual %0d",
							$time, want.result_value, result.result_value);
						fail_count++;
					end
					if (result.status !== want.status) begin
						$display("%0t: status mismatch, expected %0d actual %0d",
							$time, want.status, result.status);
						fail_count++;
					end
				end
			end
			if (push && !full) begin
				op = OP_NOP;
				if (item.symbol >= CH_ZERO && item.symbol <= CH_NINE)
					op = OP_DIGIT;
				else begin
					case (item.symbol)
						CH_PLUS:  op = OP_ADD;
						CH_MINUS: op = OP_SUB;
						CH_STAR:  op = OP_MUL;
						CH_SLASH: op = OP_DIV;
						default:  op = OP_NOP;
					endcase
				end
				if (op == OP_DIGIT) begin
					if (operand_count >= STACK_DEPTH)
						keep_first_error(ST_OVERFLOW);
					else begin
						operand_mem[operand_count] = DATA_W'(item.symbol - CH_ZERO);
						operand_count++;
					end
				end else if (op != OP_NOP) begin
					if (operand_count < 2)
						keep_first_error(ST_UNDERFLOW);
					else begin
						rhs = operand_mem[operand_count-1];
						lhs = operand_mem[operand_count-2];
						operand_count -= 2;
						pushes = 1'b1;
						res = '0;
						case (op)
							OP_ADD: res = lhs + rhs;
							OP_SUB: res = lhs - rhs;
							OP_MUL: res = lhs * rhs;
							default: begin
								if (rhs == '0) begin
									keep_first_error(ST_DIVZERO);
									pushes = 1'b0;
								end else begin
									quotient = longint'($signed(lhs)) / longint'($signed(rhs));
									res = quotient[DATA_W-1:0];
								end
							end
						endcase
						if (pushes) begin
							operand_mem[operand_count] = res;
							operand_count++;
						end
					end
				end
				if (item.end_of_expression) begin
					want.result_value = (operand_count > 0) ? operand_mem[operand_count-1] : '0;
					want.status = first_error;
					pending_results.push_back(want);
					operand_count = 0;
					first_error = ST_OK;
				end
			end
			results_due = pending_results.size();
		end
	end

endmodule

>>> bench/postfix_expression_evaluator_test.sv
// testbench top of the postfix expression evaluator: stimulus, pacing and verdict
module postfix_expression_evaluator_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pfe_pkg::*;

	localparam int              CYCLE_LIMIT = 400000;
	localparam int              HOLD_CYCLES = 400;
	localparam int              TAIL_CYCLES = 100;
	localparam logic [SYMBOL_W-1:0] SPACE_CHAR = 8'h20;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      pop = 1'b0;
	in_word_t  item = '0;
	logic      full;
	logic      empty;
	out_word_t result;

	int fail_count;
	int results_due;
	int results_seen;

	int  send_idle_pct = 8;
	int  recv_idle_pct = 73;
	bit  hold_req = 1'b0;
	int  words_sent = 0;
	int  active_sent = 0;
	int  exprs_sent = 0;
	int  overflow_runs = 0;
	int  min_div_runs = 0;
	int  cycle_count = 0;
	logic [SYMBOL_W-1:0] expr_syms [$];

	postfix_expression_evaluator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	postfix_expression_evaluator_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.item         (item),
		.empty        (empty),
		.pop          (pop),
		.result       (result),
		.fail_count   (fail_count),
		.results_due  (results_due),
		.results_seen (results_seen)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [SYMBOL_W-1:0] digit_char(input int n);
		return CH_ZERO + SYMBOL_W'(n);
	endfunction

	function automatic bit is_active(input logic [SYMBOL_W-1:0] c);
		return (c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_MINUS ||
			c == CH_STAR || c == CH_SLASH;
	endfunction

	function automatic logic [SYMBOL_W-1:0] noise_char();
		logic [SYMBOL_W-1:0] c;
		if ($urandom_range(0, 1) == 0)
			return SPACE_CHAR;
		do
			c = SYMBOL_W'($urandom_range(0, 255));
		while (is_active(c));
		return c;
	endfunction

	function automatic logic [SYMBOL_W-1:0] pick_op(input bit mul_heavy);
		if (mul_heavy && $urandom_range(0, 3) != 0)
			return CH_STAR;
		case ($urandom_range(0, 3))
			0:       return CH_PLUS;
			1:       return CH_MINUS;
			2:       return CH_STAR;
			default: return CH_SLASH;
		endcase
	endfunction

	task automatic send_word(input logic [SYMBOL_W-1:0] sym, input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push = 1'b0;
			@(negedge clk);
		end
		push = 1'b1;
		item.symbol = sym;
		item.end_of_expression = last;
		@(posedge clk);
		while (full)
			@(posedge clk);
		@(negedge clk);
		words_sent++;
		if (is_active(sym))
			active_sent++;
		if (last)
			exprs_sent++;
	endtask

	task automatic send_expr();
		foreach (expr_syms[i])
			send_word(expr_syms[i], i == expr_syms.size() - 1);
	endtask

	// random operands and operators that never underflow, with stray characters mixed in
	task automatic make_wellformed(input bit mul_heavy);
		int depth;
		int digits_left;
		depth = 0;
		digits_left = $urandom_range(1, 14);
		expr_syms.delete();
		while (digits_left > 0 || depth > 1) begin
			if ($urandom_range(0, 9) == 0)
				expr_syms.push_back(noise_char());
			if (digits_left > 0 && (depth < 2 || $urandom_range(0, 1) == 1)) begin
				expr_syms.push_back(digit_char($urandom_range(0, 9)));
				depth++;
				digits_left--;
			end else begin
				expr_syms.push_back(pick_op(mul_heavy));
				depth--;
			end
		end
	endtask

	task automatic make_overflow();
		expr_syms.delete();
		repeat ($urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 4))
			expr_syms.push_back(digit_char($urandom_range(0, 9)));
		repeat ($urandom_range(0, 4))
			expr_syms.push_back(pick_op(1'b0));
		overflow_runs++;
	endtask

	// builds 2^31, which wraps to the most negative value, then divides it
	task automatic make_min_div();
		int bits_left;
		int e;
		expr_syms.delete();
		expr_syms.push_back(digit_char(1));
		bits_left = 31;
		while (bits_left > 0) begin
			e = $urandom_range(1, (bits_left < 3) ? bits_left : 3);
			expr_syms.push_back(digit_char(1 << e));
			expr_syms.push_back(CH_STAR);
			bits_left -= e;
		end
		if ($urandom_range(0, 3) != 0) begin
			expr_syms.push_back(digit_char(0));
			expr_syms.push_back(digit_char(1));
			expr_syms.push_back(CH_MINUS);
		end else
			expr_syms.push_back(digit_char($urandom_range(0, 9)));
		expr_syms.push_back(CH_SLASH);
		min_div_runs++;
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 6))
			send_word(SYMBOL_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
	endtask

	task automatic run_random(input int target);
		int pick;
		while (words_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				make_wellformed(1'b0);
				send_expr();
			end else if (pick < 67) begin
				make_wellformed(1'b1);
				send_expr();
			end else if (pick < 75) begin
				make_overflow();
				send_expr();
			end else if (pick < 83) begin
				make_min_div();
				send_expr();
			end else
				send_noise();
		end
	endtask

	task automatic wait_drained();
		push = 1'b0;
		while (results_due != 0)
			@(negedge clk);
	endtask

	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				pop = 1'b0;
				repeat (HOLD_CYCLES)
					@(negedge clk);
				hold_req = 1'b0;
			end else
				pop = ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("postfix_expression_evaluator verification failed");
		$finish;
	end

	initial begin
		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		expr_syms = '{digit_char(0)};
		send_expr();
		expr_syms = '{digit_char(9)};
		send_expr();
		expr_syms = '{digit_char(3), digit_char(4), CH_PLUS};
		send_expr();
		expr_syms = '{digit_char(9), digit_char(8), CH_STAR};
		send_expr();
		// negative quotient truncates toward zero
		expr_syms = '{digit_char(0), digit_char(7), CH_MINUS, digit_char(2), CH_SLASH};
		send_expr();
		expr_syms = '{digit_char(5), CH_PLUS};
		send_expr();
		expr_syms = '{digit_char(4), digit_char(0), CH_SLASH};
		send_expr();
		// empty stack at the end
		send_word(8'hff, 1'b1);
		// first error kept while later characters still count
		send_word(CH_MINUS, 1'b0);
		send_word(8'h00, 1'b0);
		expr_syms = '{digit_char(3), digit_char(0), CH_SLASH, digit_char(2)};
		send_expr();

		run_random(180);
		wait_drained();

		send_idle_pct = 73;
		recv_idle_pct = 8;
		run_random(280);
		wait_drained();
		run_random(360);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 1'b1;
		repeat (12) begin
			expr_syms = '{digit_char($urandom_range(0, 9))};
			send_expr();
		end
		run_random(530);

		wait_drained();
		repeat (TAIL_CYCLES)
			@(negedge clk);
		$display("sent %0d words (%0d digits or operators) closing %0d expressions",
			words_sent, active_sent, exprs_sent);
		$display("compared %0d results, incl. %0d overflow and %0d min-value divide runs",
			results_seen, overflow_runs, min_div_runs);
		if (fail_count == 0)
			$display("postfix_expression_evaluator verification clean");
		else
			$display("postfix_expression_evaluator verification failed");
		$finish;
	end

endmodule
